// ===== hdl/omni_wheel_drive_mixer_macros.svh =====
// assertion helpers shared by the mixer modules
`ifndef OMNI_WHEEL_DRIVE_MIXER_MACROS_SVH
`define OMNI_WHEEL_DRIVE_MIXER_MACROS_SVH

// same-cycle implication, checked out of reset
`define OWM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("owm assertion failed");

// next-cycle implication, checked out of reset
`define OWM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("owm assertion failed");

`endif

// ===== hdl/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

    localparam int ROOT_W = 16;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CELLS  = ROOT_W;
    localparam int DIAG_W = 10;
    localparam int WHEELS = 4;

    localparam logic [15:0] GAIN_RESET = 16'd52429;
    localparam logic [15:0] INV_SQRT2  = 16'd46341;
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [15:0] S_FULL     = 16'd10000;
    localparam logic [18:0] BASE_MUL   = 19'd429496;
    localparam logic [8:0]  FRAC_MUL   = 9'd456;
    localparam logic [22:0] RECIP_625  = 23'd6871948;
    localparam logic [12:0] FRAC_MAX   = 13'd7296;
    localparam logic [25:0] RECIP_100  = 26'd42949673;
    localparam logic [24:0] Q_SAT      = 25'd6553600;
    localparam logic [15:0] DUTY_MAX   = 16'hFFFF;

    typedef struct packed {
        logic                          sat;
        logic [WHEELS-1:0][DIAG_W-1:0] diag;
        logic [7:0]                    z;
    } t_lane;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sqrt;

endpackage

`default_nettype wire

// ===== hdl/owm_sqrt_cell.sv =====
`default_nettype none
`include "omni_wheel_drive_mixer_macros.svh"

module owm_sqrt_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  owm_pkg::t_lane      i_lane,
    input  owm_pkg::t_sqrt      i_sq,
    output logic                o_valid,
    output owm_pkg::t_lane      o_lane,
    output owm_pkg::t_sqrt      o_sq
);

    logic                          r_valid;
    owm_pkg::t_lane                r_lane;
    owm_pkg::t_sqrt                r_sq;
    owm_pkg::t_sqrt                n_sq;
    logic [owm_pkg::REM_W+1:0]     w_acc;
    logic [owm_pkg::REM_W+1:0]     w_trial;
    logic [owm_pkg::REM_W+1:0]     w_diff;
    logic                          w_ge;
    logic [owm_pkg::REM_W-1:0]     w_rem_lim;

    // one root bit per cell: bring down two radicand bits, try (root << 2) | 1
    assign w_acc   = {i_sq.rem, i_sq.rad[owm_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_sq.root, 2'b01};
    assign w_ge    = (w_acc >= w_trial);
    assign w_diff  = w_acc - w_trial;

    always_comb begin
        n_sq.rad  = {i_sq.rad[owm_pkg::RAD_W-3:0], 2'b00};
        n_sq.root = {i_sq.root[owm_pkg::ROOT_W-2:0], w_ge};
        n_sq.rem  = w_ge ? w_diff[owm_pkg::REM_W-1:0] : w_acc[owm_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= i_lane;
            r_sq   <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_sq    = r_sq;

    // remainder never exceeds twice the partial root
    assign w_rem_lim = {1'b0, r_sq.root, 1'b0};

    `OWM_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_valid, r_sq.rem <= w_rem_lim)

endmodule

`default_nettype wire

// ===== hdl/owm_prep.sv =====
`default_nettype none
`include "omni_wheel_drive_mixer_macros.svh"

module owm_prep (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire signed [7:0]             i_axis_x,
    input  wire signed [7:0]             i_axis_y,
    input  wire signed [7:0]             i_axis_z,
    output logic                         o_valid,
    output owm_pkg::t_lane               o_lane,
    output logic [owm_pkg::RAD_W-1:0]    o_rad
);

    logic signed [8:0]  w_xn;
    logic signed [8:0]  w_y9;
    logic signed [9:0]  w_x10;
    logic signed [9:0]  w_xn10;
    logic signed [9:0]  w_y10;
    logic signed [17:0] w_xsq;
    logic signed [17:0] w_ysq;
    logic signed [17:0] w_s;

    owm_pkg::t_lane     n_lane1;
    owm_pkg::t_lane     n_lane2;
    logic [22:0]        n_frac2;
    logic [32:0]        n_base2;
    logic [45:0]        w_recip;
    logic [32:0]        n_rad4;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic [15:0]        r_s1;
    owm_pkg::t_lane     r_lane1, r_lane2, r_lane3, r_lane4;
    logic [22:0]        r_frac2;
    logic [32:0]        r_base2, r_base3;
    logic [12:0]        r_q3;
    logic [31:0]        r_rad4;

    // stage 1: negate x, squares and the four diagonal sums
    assign w_xn   = -$signed({i_axis_x[7], i_axis_x});
    assign w_y9   = $signed({i_axis_y[7], i_axis_y});
    assign w_x10  = $signed({{2{i_axis_x[7]}}, i_axis_x});
    assign w_xn10 = $signed({w_xn[8], w_xn});
    assign w_y10  = $signed({{2{i_axis_y[7]}}, i_axis_y});
    assign w_xsq  = w_xn * w_xn;
    assign w_ysq  = w_y9 * w_y9;
    assign w_s    = w_xsq + w_ysq;

    always_comb begin
        n_lane1.sat     = 1'b0;
        n_lane1.diag[0] = w_x10 + w_y10;
        n_lane1.diag[1] = w_x10 - w_y10;
        n_lane1.diag[2] = w_xn10 - w_y10;
        n_lane1.diag[3] = w_xn10 + w_y10;
        n_lane1.z       = i_axis_z;
    end

    // stick on or past the unit circle
    always_comb begin
        n_lane2     = r_lane1;
        n_lane2.sat = (r_s1 >= owm_pkg::S_FULL);
    end

    // stage 2: s * 2^28 / 625 split as integer part and fraction numerator
    assign n_frac2 = {9'd0, r_s1[13:0]} * {14'd0, owm_pkg::FRAC_MUL};
    assign n_base2 = {19'd0, r_s1[13:0]} * {14'd0, owm_pkg::BASE_MUL};

    // stage 3: fraction numerator / 625 by reciprocal
    assign w_recip = {23'd0, r_frac2} * {23'd0, owm_pkg::RECIP_625};

    // stage 4: radicand
    assign n_rad4 = r_base3 + {20'd0, r_q3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1         <= w_s[15:0];
            r_lane1      <= n_lane1;
            r_lane2      <= n_lane2;
            r_frac2      <= n_frac2;
            r_base2      <= n_base2;
            r_lane3      <= r_lane2;
            r_q3         <= w_recip[44:32];
            r_base3      <= r_base2;
            r_lane4      <= r_lane3;
            r_rad4       <= n_rad4[31:0];
        end
    end

    assign o_valid = r_v4;
    assign o_lane  = r_lane4;
    assign o_rad   = r_rad4;

    `OWM_ASSERT_IMP(a_frac_range, i_clk, i_rst_n, r_v3 && !r_lane3.sat, r_q3 < owm_pkg::FRAC_MAX)

endmodule

`default_nettype wire

// ===== hdl/owm_wheel.sv =====
`default_nettype none
`include "omni_wheel_drive_mixer_macros.svh"

module owm_wheel (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [31:0]          i_kr,
    input  wire signed [25:0]   i_rw,
    input  wire signed [9:0]    i_diag,
    input  wire [15:0]          i_gain,
    output logic                o_valid,
    output logic [15:0]         o_duty,
    output logic                o_reverse
);

    logic signed [42:0] n_kd;
    logic signed [42:0] w_cmd;
    logic signed [42:0] w_abs;
    logic               w_neg;
    logic [56:0]        w_p;
    logic [24:0]        w_q;
    logic [48:0]        w_dq;

    logic               r_vb, r_vc, r_vd, r_ve, r_vf;
    logic signed [42:0] r_kd;
    logic signed [41:0] r_rot;
    logic [40:0]        r_mag;
    logic               r_rev_c, r_rev_d, r_rev_e, r_rev_f;
    logic [32:0]        r_ph;
    logic [39:0]        r_pl;
    logic [22:0]        r_q;
    logic               r_qsat;
    logic [15:0]        r_duty;
    logic [31:0]        w_lo;
    logic [31:0]        w_q32;

    // stage b: translation term
    assign n_kd = $signed({1'b0, i_kr}) * i_diag;

    // stage c: wheel command, sign and magnitude
    assign w_cmd = r_kd + {r_rot[41], r_rot};
    assign w_neg = w_cmd[42];
    assign w_abs = w_neg ? -w_cmd : w_cmd;

    // stage e: product / 2^32, then saturate check
    assign w_p = {r_ph, 24'd0} + {17'd0, r_pl};
    assign w_q = w_p[56:32];

    // stage f: / 100 by reciprocal
    assign w_dq = {26'd0, r_q} * {23'd0, owm_pkg::RECIP_100};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_vb <= i_valid;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kd    <= n_kd;
            r_rot   <= $signed({i_rw, 16'd0});
            r_mag   <= w_abs[40:0];
            r_rev_c <= w_neg || (w_cmd == '0);
            r_ph    <= {16'd0, r_mag[40:24]} * {17'd0, i_gain};
            r_pl    <= {16'd0, r_mag[23:0]} * {24'd0, i_gain};
            r_rev_d <= r_rev_c;
            r_q     <= w_q[22:0];
            r_qsat  <= (w_q >= owm_pkg::Q_SAT);
            r_rev_e <= r_rev_d;
            r_duty  <= r_qsat ? owm_pkg::DUTY_MAX : w_dq[47:32];
            r_rev_f <= r_rev_e;
        end
    end

    assign o_valid   = r_vf;
    assign o_duty    = r_duty;
    assign o_reverse = r_rev_f;

    // duty is the floored quotient of the scaled magnitude by 100 when not saturated
    assign w_lo  = {16'd0, r_duty} * 32'd100;
    assign w_q32 = {9'd0, r_q};

    `OWM_ASSERT_NXT(a_div_lo, i_clk, i_rst_n, r_ve && i_en && !r_qsat, w_lo <= $past(w_q32))
    `OWM_ASSERT_NXT(a_div_hi, i_clk, i_rst_n, r_ve && i_en && !r_qsat, $past(w_q32) < w_lo + 32'd100)

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_drive_mixer.sv =====
`default_nettype none

// Four-wheel X omni base mixer. Each input word is one joystick sample (x, y, z in
// hundredths, signed 8 bit); each output word carries a Q0.16 duty and a reverse bit
// for the four wheels (front right, front left, rear left, rear right). x is negated,
// the translation share r = |(x, y)| is clamped to 1.0, the diagonal terms get
// r / sqrt2 and the rotation term gets (1 - r) * z; the command magnitude is scaled
// by motor_gain (Q0.16, reset 52429 ~ 0.8) and saturates at 65535, reverse is set
// for a zero or negative command. The block takes one word every clock cycle while the
// output word is taken; from input accept to output valid lie 4 front-end stages
// (squares, divide by 10000 via reciprocal), 16 square-root cells that each settle
// one root bit, one weighting stage and 5 per-wheel stages (multiply, sign/magnitude,
// gain, divide by 100). All stages move together and stall as one when the output
// word is not taken. motor_gain is written through the cfg port, always ready; write
// it only while no word is in flight.
module omni_wheel_drive_mixer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // sample input
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [7:0]   i_axis_x,
    input  wire signed [7:0]   i_axis_y,
    input  wire signed [7:0]   i_axis_z,
    // wheel output
    output logic               o_valid,
    input  wire                i_ready,
    output logic [15:0]        o_front_right_duty,
    output logic               o_front_right_reverse,
    output logic [15:0]        o_front_left_duty,
    output logic               o_front_left_reverse,
    output logic [15:0]        o_rear_left_duty,
    output logic               o_rear_left_reverse,
    output logic [15:0]        o_rear_right_duty,
    output logic               o_rear_right_reverse,
    // motor_gain write port
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [15:0]         i_motor_gain
);

    localparam int CELLS  = owm_pkg::CELLS;
    localparam int WHEELS = owm_pkg::WHEELS;

    logic                      w_en;
    logic [15:0]               r_gain;

    // cell chain taps
    logic [CELLS:0]            w_cv;
    owm_pkg::t_lane            w_cl [0:CELLS];
    owm_pkg::t_sqrt            w_cs [0:CELLS];
    logic [owm_pkg::RAD_W-1:0] w_rad;

    // weighting stage
    logic [16:0]               n_r;
    logic [16:0]               w_rot_share;
    logic [32:0]               w_kr_full;
    logic signed [25:0]        n_rw;
    logic                      r_va;
    logic [31:0]               r_kr;
    logic signed [25:0]        r_rw;
    owm_pkg::t_lane            r_lane_a;

    logic [WHEELS-1:0]         w_wv;
    logic [15:0]               w_duty [0:WHEELS-1];
    logic [WHEELS-1:0]         w_rev;

    // whole pipeline advances unless the output word is held
    assign w_en        = !o_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= owm_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_motor_gain;
        end
    end

    // front end: negate, squares, radicand s * 2^32 / 10000
    owm_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_valid  (w_cv[0]),
        .o_lane   (w_cl[0]),
        .o_rad    (w_rad)
    );

    always_comb begin
        w_cs[0].rad  = w_rad;
        w_cs[0].root = '0;
        w_cs[0].rem  = '0;
    end

    // square-root chain, msb of the root first
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        owm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[c]),
            .i_lane  (w_cl[c]),
            .i_sq    (w_cs[c]),
            .o_valid (w_cv[c+1]),
            .o_lane  (w_cl[c+1]),
            .o_sq    (w_cs[c+1])
        );
    end

    // r clamps to 1.0 when s reaches 10000 (stick on or past the unit circle)
    assign n_r         = w_cl[CELLS].sat ? owm_pkg::ONE_Q16 : {1'b0, w_cs[CELLS].root};
    assign w_rot_share = owm_pkg::ONE_Q16 - n_r;
    assign w_kr_full   = {17'd0, owm_pkg::INV_SQRT2} * {16'd0, n_r};
    assign n_rw        = $signed({1'b0, w_rot_share}) * $signed(w_cl[CELLS].z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= w_cv[CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kr     <= w_kr_full[31:0];
            r_rw     <= n_rw;
            r_lane_a <= w_cl[CELLS];
        end
    end

    // one lane per wheel, diag order: fr, fl, rl, rr
    for (genvar k = 0; k < WHEELS; k++) begin : g_wheel
        owm_wheel u_wheel (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (r_va),
            .i_kr      (r_kr),
            .i_rw      (r_rw),
            .i_diag    ($signed(r_lane_a.diag[k])),
            .i_gain    (r_gain),
            .o_valid   (w_wv[k]),
            .o_duty    (w_duty[k]),
            .o_reverse (w_rev[k])
        );
    end

    assign o_valid               = &w_wv;
    assign o_front_right_duty    = w_duty[0];
    assign o_front_right_reverse = w_rev[0];
    assign o_front_left_duty     = w_duty[1];
    assign o_front_left_reverse  = w_rev[1];
    assign o_rear_left_duty      = w_duty[2];
    assign o_rear_left_reverse   = w_rev[2];
    assign o_rear_right_duty     = w_duty[3];
    assign o_rear_right_reverse  = w_rev[3];

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // one output word: duty and reverse bit per wheel, index 0 is front right
    typedef struct packed {
        logic [3:0][15:0] duty;
        logic [3:0]       reverse;
    } t_wheels;

    // keeps the expected wheel words and the motor gain the block should be using
    class wheel_scoreboard;
        t_wheels     pending_q[$];
        logic [15:0] gain;
        int          mismatches;
        int          samples;
        int          words;
        string       wheel_tag[4];

        function new();
            gain = owm_pkg::GAIN_RESET;
            mismatches = 0;
            samples = 0;
            words = 0;
            wheel_tag = '{"front_right", "front_left", "rear_left", "rear_right"};
        endfunction

        function void set_gain(logic [15:0] g);
            gain = g;
        endfunction

        // floored square root, one result bit per step from the top
        function longint root_floor(longint n);
            longint acc;
            longint trial;
            acc = 0;
            for (int b = 18; b >= 0; b--) begin
                trial = acc + (longint'(1) << b);
                if (trial * trial <= n)
                    acc = trial;
            end
            return acc;
        endfunction

        function t_wheels mix_sample(logic signed [7:0] ax, logic signed [7:0] ay,
                                     logic signed [7:0] az);
            t_wheels     w;
            longint      xn, y, z, r, rot, cmd;
            longint      diag[4];
            logic [63:0] mag;
            logic [79:0] scaled;
            logic [79:0] quot;
            // x is negated on the way in, -128 becomes +128
            xn = -longint'(ax);
            y = longint'(ay);
            z = longint'(az);
            // translation share in Q16, clamped to one beyond the unit circle
            r = root_floor(((xn * xn + y * y) << 32) / 10000);
            if (r > longint'(owm_pkg::ONE_Q16))
                r = longint'(owm_pkg::ONE_Q16);
            rot = (longint'(owm_pkg::ONE_Q16) - r) * z * longint'(owm_pkg::ONE_Q16);
            diag[0] = -xn + y;
            diag[1] = -xn - y;
            diag[2] = xn - y;
            diag[3] = xn + y;
            for (int k = 0; k < 4; k++) begin
                cmd = longint'(owm_pkg::INV_SQRT2) * r * diag[k] + rot;
                mag = (cmd < 0) ? 64'(-cmd) : 64'(cmd);
                // product kept at full width so large commands saturate
                scaled = 80'(mag) * 80'(gain);
                quot = scaled / (80'd100 << 32);
                w.duty[k] = (quot > 80'(owm_pkg::DUTY_MAX)) ? owm_pkg::DUTY_MAX : quot[15:0];
                w.reverse[k] = (cmd <= 0);
            end
            return w;
        endfunction

        function void note_sample(logic signed [7:0] ax, logic signed [7:0] ay,
                                  logic signed [7:0] az);
            pending_q.push_back(mix_sample(ax, ay, az));
            samples++;
        endfunction

        function void check_wheels(t_wheels got);
            t_wheels want;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected wheel word, nothing pending", $time);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            words++;
            for (int k = 0; k < 4; k++) begin
                if (got.duty[k] !== want.duty[k]) begin
                    $display("%0t %s duty: expected %0d actual %0d", $time, wheel_tag[k],
                             want.duty[k], got.duty[k]);
                    mismatches++;
                end
                if (got.reverse[k] !== want.reverse[k]) begin
                    $display("%0t %s reverse: expected %0d actual %0d", $time,
                             wheel_tag[k], want.reverse[k], got.reverse[k]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;
    localparam int SEG_ITEMS   = 160;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic signed [7:0] i_axis_x = '0;
    logic signed [7:0] i_axis_y = '0;
    logic signed [7:0] i_axis_z = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [15:0]       o_front_right_duty;
    logic              o_front_right_reverse;
    logic [15:0]       o_front_left_duty;
    logic              o_front_left_reverse;
    logic [15:0]       o_rear_left_duty;
    logic              o_rear_left_reverse;
    logic [15:0]       o_rear_right_duty;
    logic              o_rear_right_reverse;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [15:0]       i_motor_gain = '0;

    wheel_scoreboard sb;
    int              send_idle_pct = 0;   // chance per cycle that the sender holds off
    int              recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int              quiet_cycles = 0;
    int              gain_writes = 0;

    omni_wheel_drive_mixer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_axis_x              (i_axis_x),
        .i_axis_y              (i_axis_y),
        .i_axis_z              (i_axis_z),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_front_right_duty    (o_front_right_duty),
        .o_front_right_reverse (o_front_right_reverse),
        .o_front_left_duty     (o_front_left_duty),
        .o_front_left_reverse  (o_front_left_reverse),
        .o_rear_left_duty      (o_rear_left_duty),
        .o_rear_left_reverse   (o_rear_left_reverse),
        .o_rear_right_duty     (o_rear_right_duty),
        .o_rear_right_reverse  (o_rear_right_reverse),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_motor_gain          (i_motor_gain)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: random stalls at the current rate, none at zero
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // samples taken at the edge see the values from before it, so no ordering races
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            sb.note_sample(i_axis_x, i_axis_y, i_axis_z);
    end

    always @(posedge i_clk) begin
        t_wheels got;
        if (i_rst_n && o_valid && i_ready) begin
            got.duty = {o_rear_right_duty, o_rear_left_duty, o_front_left_duty,
                        o_front_right_duty};
            got.reverse = {o_rear_right_reverse, o_rear_left_reverse, o_front_left_reverse,
                           o_front_right_reverse};
            sb.check_wheels(got);
        end
    end

    // watchdog: ends a run in which no word moves on any port for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t timeout, %0d words still pending", $time, sb.pending_q.size());
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one joystick word; valid is left high so back-to-back words need no gap
    task automatic send_sample(input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_axis_x <= x;
        i_axis_y <= y;
        i_axis_z <= z;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // sender pause: everything in flight has come back
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
    endtask

    // gain write, only issued with the pipe empty
    task automatic write_gain(input logic [15:0] g);
        i_cfg_valid <= 1'b1;
        i_motor_gain <= g;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_gain(g);
        gain_writes++;
    endtask

    // mostly sticks in range, some raw byte patterns and corner values
    function automatic logic [7:0] pick_axis();
        int unsigned sel;
        int          corner_vals[9];
        corner_vals = '{-128, -127, -100, -1, 0, 1, 100, 126, 127};
        sel = $urandom_range(99);
        if (sel < 70)
            return 8'(int'($urandom_range(200)) - 100);
        else if (sel < 85)
            return 8'($urandom());
        else
            return 8'(corner_vals[$urandom_range(8)]);
    endfunction

    initial begin
        int          directed[24][3];
        int          pace_send[4];
        int          pace_recv[4];
        logic [15:0] seg_gain[8];
        sb = new();
        // zero stick, each axis alone at full, both diagonals, raw extremes,
        // x at -128, points inside / on / just past the circle, a wheel cancelling out
        directed = '{
            '{0, 0, 0}, '{100, 0, 0}, '{-100, 0, 0}, '{0, 100, 0}, '{0, -100, 0},
            '{0, 0, 100}, '{0, 0, -100}, '{100, 100, 100}, '{-100, -100, -100},
            '{-128, -128, -128}, '{127, 127, 127}, '{-128, 0, 0}, '{127, -128, 0},
            '{50, 50, 0}, '{30, 40, 50}, '{60, 80, 20}, '{71, 71, 50}, '{1, 0, 0},
            '{0, 1, -1}, '{0, 0, 1}, '{-1, -1, -1}, '{10, -10, 0}, '{-10, 10, 37},
            '{-128, 127, -128}
        };
        // pacing modes: free running, slow sender, slow receiver, both ragged
        pace_send = '{0, 81, 0, 29};
        pace_recv = '{0, 0, 81, 29};
        seg_gain = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                     16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     owm_pkg::GAIN_RESET, 16'hFFFF};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset gain, no idling
        for (int i = 0; i < 24; i++)
            send_sample(8'(directed[i][0]), 8'(directed[i][1]), 8'(directed[i][2]));
        drain_pipe();

        for (int seg = 0; seg < 8; seg++) begin
            send_idle_pct = pace_send[seg / 2];
            recv_stall_pct <= pace_recv[seg / 2];
            write_gain(seg_gain[seg]);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_sample(pick_axis(), pick_axis(), pick_axis());
            drain_pipe();
        end

        // let anything stray fall out of the pipeline
        repeat (40) @(posedge i_clk);

        $display("run covered %0d joystick words and %0d wheel words checked,", sb.samples,
                 sb.words);
        $display("%0d gain writes from 0 to 65535 under four pacing modes", gain_writes);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
